FILE: rtl/core/nalsc_pkg.sv
// Package for the Annex B start code splitter.
// Holds parse phases, input codes, byte constants and the queue entry type.
// No dependencies.
`default_nettype none

package nalsc_pkg;

  localparam int unsigned MAX_UNIT_BYTES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH        = 4;

  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_EPB  = 8'h03;

  typedef enum logic [2:0] {
    PH_SEARCH0,
    PH_SEARCH1,
    PH_SEARCH2,
    PH_HDR1,
    PH_HDR2,
    PH_PAYLOAD,
    PH_ZERO1,
    PH_ZERO2
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_END,
    TAIL_DROP,
    TAIL_EMU
  } tail_t;

  // One request's worth of results: leading zeros, an optional byte, a tail.
  typedef struct packed {
    logic [1:0]  zeros;
    logic        has_byte;
    tail_t       tail;
    logic [7:0]  data;
    logic [15:0] pos;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/nalsc_in_if.sv
// Input channel of the start code splitter: valid, ready and one stream request.
// Depends on nothing.
`default_nettype none

interface nalsc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nalsc_out_if.sv
// Result channel of the start code splitter: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface nalsc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        unit_end;
  logic        unit_drop;
  logic        emulation_removed;
  logic [15:0] skip_position;
  logic        last;

  modport source (output valid, output out_byte, output byte_valid, output unit_end,
                  output unit_drop, output emulation_removed, output skip_position,
                  output last, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input unit_end,
                input unit_drop, input emulation_removed, input skip_position,
                input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/nalsc_front.sv
// Front end: accepts stream requests, tracks the parse phase and unit counters,
// and pushes one queue entry per request that yields results. Uses nalsc_pkg.
`default_nettype none

module nalsc_front #(
  parameter int unsigned MAX_UNIT_BYTES = nalsc_pkg::MAX_UNIT_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  nalsc_in_if.sink          in_chan,
  input  wire logic         q_full,
  output logic              q_push,
  output nalsc_pkg::entry_t q_entry
);

  localparam logic [15:0] PosLimit =
    ((MAX_UNIT_BYTES - 1) < 65535) ? 16'(MAX_UNIT_BYTES - 1) : 16'hFFFF;

  nalsc_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] emitted_r, emitted_nxt;
  logic [15:0] skipped_r, skipped_nxt;

  logic        accept;
  logic [7:0]  b;
  logic [16:0] emu_sum;
  logic [15:0] emu_emitted;
  logic [15:0] emu_pos;

  function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [1:0] k);
    logic [16:0] s;
    s = {1'b0, v} + {15'd0, k};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign b             = in_chan.in_byte;

  assign emu_emitted = sat_add(emitted_r, 2'd2);
  assign emu_sum     = {1'b0, emu_emitted} + {1'b0, skipped_r};
  assign emu_pos     = (emu_sum > {1'b0, PosLimit}) ? PosLimit : emu_sum[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= nalsc_pkg::PH_SEARCH0;
      emitted_r <= '0;
      skipped_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      emitted_r <= emitted_nxt;
      skipped_r <= skipped_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    emitted_nxt      = emitted_r;
    skipped_nxt      = skipped_r;
    q_push           = 1'b0;
    q_entry.zeros    = 2'd0;
    q_entry.has_byte = 1'b0;
    q_entry.tail     = nalsc_pkg::TAIL_NONE;
    q_entry.data     = b;
    q_entry.pos      = '0;
    if (accept) begin
      if (in_chan.kind == nalsc_pkg::KIND_FLUSH) begin
        phase_nxt   = nalsc_pkg::PH_SEARCH0;
        emitted_nxt = '0;
        skipped_nxt = '0;
        unique case (phase_r) inside
          nalsc_pkg::PH_PAYLOAD: begin
            q_push       = 1'b1;
            q_entry.tail = nalsc_pkg::TAIL_END;
          end
          nalsc_pkg::PH_ZERO1: begin
            q_push        = 1'b1;
            q_entry.zeros = 2'd1;
            q_entry.tail  = nalsc_pkg::TAIL_END;
          end
          nalsc_pkg::PH_ZERO2: begin
            q_push        = 1'b1;
            q_entry.zeros = 2'd2;
            q_entry.tail  = nalsc_pkg::TAIL_END;
          end
          nalsc_pkg::PH_HDR1, nalsc_pkg::PH_HDR2: begin
            q_push       = 1'b1;
            q_entry.tail = nalsc_pkg::TAIL_DROP;
          end
          default: begin
            q_push = 1'b0;
          end
        endcase
      end else begin
        unique case (phase_r)
          nalsc_pkg::PH_SEARCH0: begin
            phase_nxt = (b == nalsc_pkg::BYTE_ZERO) ? nalsc_pkg::PH_SEARCH1
                                                    : nalsc_pkg::PH_SEARCH0;
          end
          nalsc_pkg::PH_SEARCH1: begin
            phase_nxt = (b == nalsc_pkg::BYTE_ZERO) ? nalsc_pkg::PH_SEARCH2
                                                    : nalsc_pkg::PH_SEARCH0;
          end
          nalsc_pkg::PH_SEARCH2: begin
            if (b == nalsc_pkg::BYTE_ONE) begin
              phase_nxt   = nalsc_pkg::PH_HDR1;
              emitted_nxt = '0;
              skipped_nxt = '0;
            end else if (b != nalsc_pkg::BYTE_ZERO) begin
              phase_nxt = nalsc_pkg::PH_SEARCH0;
            end
          end
          nalsc_pkg::PH_HDR1: begin
            q_push           = 1'b1;
            q_entry.has_byte = 1'b1;
            emitted_nxt      = sat_add(emitted_r, 2'd1);
            phase_nxt        = nalsc_pkg::PH_HDR2;
          end
          nalsc_pkg::PH_HDR2: begin
            q_push           = 1'b1;
            q_entry.has_byte = 1'b1;
            emitted_nxt      = sat_add(emitted_r, 2'd1);
            phase_nxt        = nalsc_pkg::PH_PAYLOAD;
          end
          nalsc_pkg::PH_PAYLOAD: begin
            if (b == nalsc_pkg::BYTE_ZERO) begin
              phase_nxt = nalsc_pkg::PH_ZERO1;
            end else begin
              q_push           = 1'b1;
              q_entry.has_byte = 1'b1;
              emitted_nxt      = sat_add(emitted_r, 2'd1);
            end
          end
          nalsc_pkg::PH_ZERO1: begin
            if (b == nalsc_pkg::BYTE_ZERO) begin
              phase_nxt = nalsc_pkg::PH_ZERO2;
            end else begin
              q_push           = 1'b1;
              q_entry.zeros    = 2'd1;
              q_entry.has_byte = 1'b1;
              emitted_nxt      = sat_add(emitted_r, 2'd2);
              phase_nxt        = nalsc_pkg::PH_PAYLOAD;
            end
          end
          nalsc_pkg::PH_ZERO2: begin
            if (b == nalsc_pkg::BYTE_ZERO) begin
              q_push        = 1'b1;
              q_entry.zeros = 2'd1;
              emitted_nxt   = sat_add(emitted_r, 2'd1);
            end else if (b == nalsc_pkg::BYTE_EPB) begin
              q_push        = 1'b1;
              q_entry.zeros = 2'd1;
              q_entry.tail  = nalsc_pkg::TAIL_EMU;
              q_entry.pos   = emu_pos;
              emitted_nxt   = emu_emitted;
              skipped_nxt   = sat_add(skipped_r, 2'd1);
              phase_nxt     = nalsc_pkg::PH_PAYLOAD;
            end else if (b == nalsc_pkg::BYTE_ONE) begin
              q_push       = 1'b1;
              q_entry.tail = nalsc_pkg::TAIL_END;
              emitted_nxt  = '0;
              skipped_nxt  = '0;
              phase_nxt    = nalsc_pkg::PH_HDR1;
            end else begin
              q_push           = 1'b1;
              q_entry.zeros    = 2'd2;
              q_entry.has_byte = 1'b1;
              emitted_nxt      = sat_add(emitted_r, 2'd3);
              phase_nxt        = nalsc_pkg::PH_PAYLOAD;
            end
          end
          default: begin
            phase_nxt = nalsc_pkg::PH_SEARCH0;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nalsc_queue.sv
// Small entry queue between the front and back ends of the splitter.
// Uses nalsc_pkg for the entry type and depth.
`default_nettype none

module nalsc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire nalsc_pkg::entry_t push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output nalsc_pkg::entry_t      head_entry
);

  localparam int unsigned Depth = nalsc_pkg::QUEUE_DEPTH;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  nalsc_pkg::entry_t slots_r [Depth];
  logic [AddrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]   count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AddrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AddrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nalsc_back.sv
// Back end: expands the queue head entry into one result per cycle while out_chan.ready is high.
// Uses nalsc_pkg for the entry type and tail codes.
`default_nettype none

module nalsc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire nalsc_pkg::entry_t head_entry,
  output logic                   pop,
  nalsc_out_if.source            out_chan
);

  logic [1:0] idx_r;
  logic [1:0] total;
  logic       is_last;
  logic       in_zeros;
  logic       at_byte;
  logic       take;

  assign total    = head_entry.zeros + {1'b0, head_entry.has_byte}
                  + {1'b0, head_entry.tail != nalsc_pkg::TAIL_NONE};
  assign is_last  = (idx_r == total - 2'd1);
  assign in_zeros = (idx_r < head_entry.zeros);
  assign at_byte  = !in_zeros && head_entry.has_byte && (idx_r == head_entry.zeros);
  assign take     = head_valid && out_chan.ready;
  assign pop      = take && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_comb begin
    out_chan.valid             = head_valid;
    out_chan.last              = is_last;
    out_chan.out_byte          = nalsc_pkg::BYTE_ZERO;
    out_chan.byte_valid        = 1'b0;
    out_chan.unit_end          = 1'b0;
    out_chan.unit_drop         = 1'b0;
    out_chan.emulation_removed = 1'b0;
    out_chan.skip_position     = '0;
    if (in_zeros) begin
      out_chan.byte_valid = 1'b1;
    end else if (at_byte) begin
      out_chan.out_byte   = head_entry.data;
      out_chan.byte_valid = 1'b1;
    end else begin
      case (head_entry.tail)
        nalsc_pkg::TAIL_END:  out_chan.unit_end  = 1'b1;
        nalsc_pkg::TAIL_DROP: out_chan.unit_drop = 1'b1;
        nalsc_pkg::TAIL_EMU: begin
          out_chan.byte_valid        = 1'b1;
          out_chan.emulation_removed = 1'b1;
          out_chan.skip_position     = head_entry.pos;
        end
        default: out_chan.byte_valid = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/annexb_nal_start_code_splitter_core.sv
// Top level of the Annex B start code splitter: front end, entry queue, back end.
// Uses nalsc_pkg, nalsc_in_if, nalsc_out_if, nalsc_front, nalsc_queue, nalsc_back.
//
// The block takes one stream byte or flush request per cycle while the queue is
// not full and drops 00 00 01 start codes and emulation prevention bytes. Each
// accepted request that yields results becomes one entry in a four-entry queue;
// the back end then sends that entry's one to three results in order, one each
// time the result port takes one; an entry's first result is offered once it is
// in the queue and at its head. Input ready drops only while the queue is full.
// skip_position saturates at the smaller of MAX_UNIT_BYTES - 1 and 65535.
`default_nettype none

module annexb_nal_start_code_splitter_core #(
  parameter int unsigned MAX_UNIT_BYTES = nalsc_pkg::MAX_UNIT_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  nalsc_in_if.sink    in_chan,
  nalsc_out_if.source out_chan
);

  logic              q_push, q_full, q_pop, q_head_valid;
  nalsc_pkg::entry_t q_entry, q_head_entry;

  nalsc_front #(
    .MAX_UNIT_BYTES(MAX_UNIT_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  nalsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  nalsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire
